// ===== rtl/aes_cbc_pkg.sv =====
// Package for the AES-256 CBC decrypt core: widths, register indexes,
// S-box tables and GF(2^8) helpers. No dependencies.
package aes_cbc_pkg;

  localparam int unsigned RegW   = 64;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned NumRounds = 14;
  localparam int unsigned NumKeys = 15;
  localparam int unsigned RkIdxW = 4;
  localparam int unsigned NumWords = 60;
  localparam int unsigned WordIdxW = 6;

  typedef enum logic [RegIdxW-1:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_IV_HI = 3'd4,
    REG_IV_LO = 3'd5
  } reg_idx_t;

  // controller -> datapath commands
  typedef struct packed {
    logic                   kx_start;   // load key words into expander window
    logic                   kx_step;    // produce next key word
    logic                   blk_load;   // take the input beat, add round key 14
    logic                   rnd_step;   // one inverse round
    logic                   rnd_last;   // final round has no InvMixColumns
    logic [RkIdxW-1:0]      rk_sel;     // round key used in this cycle
    logic                   out_load;   // latch plaintext into output reg
  } dp_cmd_t;

  typedef struct packed {
    logic kx_done;
  } dp_sts_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // x*9, x*11, x*13, x*14 from x, 2x, 4x, 8x
  function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] x2, x4, x8;
    for (int i = 0; i < 4; i++) begin
      a[i] = col[31-8*i -: 8];
      x2 = xt(a[i]);
      x4 = xt(x2);
      x8 = xt(x4);
      m9[i] = x8 ^ a[i];
      mb[i] = x8 ^ x2 ^ a[i];
      md[i] = x8 ^ x4 ^ a[i];
      me[i] = x8 ^ x4 ^ x2;
    end
    inv_mix_col = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                   m9[0] ^ me[1] ^ mb[2] ^ md[3],
                   md[0] ^ m9[1] ^ me[2] ^ mb[3],
                   mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

endpackage

// ===== rtl/aes_cbc_stream_if.sv =====
// Valid/ready stream interface carrying a typed payload.
// No dependencies.
interface aes_cbc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/aes256_cbc_decrypt_core.sv =====
// Top level of the AES-256 CBC decrypt core.
// Depends on aes_cbc_pkg, aes_cbc_stream_if, aes_cbc_ctrl, aes_cbc_datapath.
//
// Use:
//   in_s  : ciphertext beats {ct_high, ct_low, start_message}, valid/ready.
//   out_s : plaintext beats {pt_high, pt_low}, valid/ready.
//   cfg   : write port, index 0..3 key words, 4..5 IV; write only when idle.
// After reset, or after any key write, the first block waits for key
// expansion, one key word per cycle, filling the 15-entry round key
// store. Expansion starts once a beat is offered.
// Per block: an accept step (round key 14 added), 14 inverse rounds (one
// shared inverse round unit), then a write of the output register.
// CBC chaining serializes blocks.
// start_message picks the IV; otherwise the previous ciphertext chains.
// Reset clears config, chaining value and the valid flag of the output.
// If the receiver stalls, the result sits in the output register; the
// next block may still be accepted and processed, and then waits after
// its last round until the output register frees.
module aes256_cbc_decrypt_core (
  input  logic                             clk,
  input  logic                             rst,
  aes_cbc_stream_if.sink                   in_s,
  aes_cbc_stream_if.source                 out_s,
  input  logic                             cfg_we,
  input  logic [aes_cbc_pkg::RegIdxW-1:0]  cfg_idx,
  input  logic [aes_cbc_pkg::RegW-1:0]     cfg_data
);
  import aes_cbc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    keys_ready;
  logic [127:0] pt;

  aes_cbc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .keys_ready (keys_ready),
    .in_valid   (in_s.valid),
    .in_ready   (in_s.ready),
    .out_valid  (out_s.valid),
    .out_ready  (out_s.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  aes_cbc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .ct            ({in_s.payload.ct_high, in_s.payload.ct_low}),
    .start_message (in_s.payload.start_message),
    .pt            (pt),
    .keys_ready    (keys_ready),
    .cmd           (cmd),
    .sts           (sts)
  );

  assign out_s.payload.pt_high = pt[127:64];
  assign out_s.payload.pt_low  = pt[63:0];
endmodule

// ===== rtl/aes_cbc_ctrl.sv =====
// Controller FSM for the AES-256 CBC decrypt core.
// Depends on aes_cbc_pkg.
module aes_cbc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  keys_ready,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aes_cbc_pkg::dp_cmd_t  cmd,
  input  aes_cbc_pkg::dp_sts_t  sts
);
  import aes_cbc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_KEXP = 5'b00010,
    ST_RND  = 5'b00100,
    ST_DONE = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [RkIdxW-1:0] rnd, rnd_next;
  logic out_full, out_full_next;

  assign out_valid = out_full;
  // accept a new block while the previous result waits, if keys are expanded
  assign in_ready = (state == ST_IDLE) && keys_ready;

  always_comb begin
    state_next = state;
    rnd_next = rnd;
    out_full_next = out_full;
    cmd = '0;
    cmd.rk_sel = rnd;
    if (out_full && out_ready) out_full_next = 1'b0;
    case (state)
      ST_IDLE: begin
        // expand on demand, once a beat is offered, from the current key
        if (in_valid && !keys_ready) begin
          cmd.kx_start = 1'b1;
          state_next = ST_KEXP;
        end else if (in_valid) begin
          cmd.blk_load = 1'b1;
          cmd.rk_sel = RkIdxW'(NumRounds);
          rnd_next = RkIdxW'(NumRounds - 1);
          state_next = ST_RND;
        end
      end
      ST_KEXP: begin
        cmd.kx_step = 1'b1;
        if (sts.kx_done) state_next = ST_IDLE;
      end
      ST_RND: begin
        cmd.rnd_step = 1'b1;
        cmd.rnd_last = (rnd == '0);
        rnd_next = rnd - 1'b1;
        if (rnd == '0) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_full_next) begin
          cmd.out_load = 1'b1;
          out_full_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      rnd <= rnd_next;
      out_full <= out_full_next;
    end
  end
endmodule

// ===== rtl/aes_cbc_datapath.sv =====
// Datapath: key registers, key expander, round key store, round unit,
// chaining and output register. Depends on aes_cbc_pkg.
module aes_cbc_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [aes_cbc_pkg::RegIdxW-1:0]   cfg_idx,
  input  logic [aes_cbc_pkg::RegW-1:0]      cfg_data,
  input  logic [127:0]                      ct,
  input  logic                              start_message,
  output logic [127:0]                      pt,
  output logic                              keys_ready,
  input  aes_cbc_pkg::dp_cmd_t              cmd,
  output aes_cbc_pkg::dp_sts_t              sts
);
  import aes_cbc_pkg::*;

  logic [RegW-1:0] key_reg [4];
  logic [RegW-1:0] iv_reg [2];
  logic [127:0] chain;
  logic [127:0] chain_sel;
  logic [127:0] st;
  logic [127:0] ct_hold;

  // key expansion: sliding window of 8 words, one new word per cycle
  logic [31:0] win [8];
  logic [WordIdxW-1:0] widx;
  logic [7:0] rc;
  logic [31:0] kt, kw;
  logic [31:0] rk_lo_word;
  logic [127:0] rk_mem [NumKeys];
  logic [127:0] rk;

  always_comb begin
    kt = win[7];
    if (widx[2:0] == 3'd0) begin
      kt = {FWD_SBOX[win[7][23:16]], FWD_SBOX[win[7][15:8]],
            FWD_SBOX[win[7][7:0]], FWD_SBOX[win[7][31:24]]} ^ {rc, 24'h0};
    end else if (widx[2:0] == 3'd4) begin
      kt = {FWD_SBOX[win[7][31:24]], FWD_SBOX[win[7][23:16]],
            FWD_SBOX[win[7][15:8]], FWD_SBOX[win[7][7:0]]};
    end
    kw = win[0] ^ kt;
  end
  assign rk_lo_word = win[7];
  assign sts.kx_done = cmd.kx_step && (widx == WordIdxW'(NumWords - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_ready <= 1'b0;
      for (int i = 0; i < 4; i++) key_reg[i] <= '0;
      iv_reg[0] <= '0;
      iv_reg[1] <= '0;
      chain <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_reg[cfg_idx[1:0]] <= cfg_data;
          REG_IV_HI: iv_reg[0] <= cfg_data;
          REG_IV_LO: iv_reg[1] <= cfg_data;
          default: ;
        endcase
      end
      // a key write always invalidates the store
      if (cfg_we && (cfg_idx <= REG_KEY3)) keys_ready <= 1'b0;
      else if (sts.kx_done) keys_ready <= 1'b1;
      if (cmd.blk_load) chain <= ct;
    end
  end

  // window and round key store writes (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.kx_start) begin
      for (int i = 0; i < 4; i++) begin
        win[2*i] <= key_reg[i][63:32];
        win[2*i+1] <= key_reg[i][31:0];
      end
      widx <= WordIdxW'(8);
      rc <= 8'h01;
      rk_mem[0] <= {key_reg[0], key_reg[1]};
      rk_mem[1] <= {key_reg[2], key_reg[3]};
    end else if (cmd.kx_step) begin
      for (int i = 0; i < 7; i++) win[i] <= win[i+1];
      win[7] <= kw;
      widx <= widx + 1'b1;
      if (widx[2:0] == 3'd0) rc <= xt(rc);
      if (widx[1:0] == 2'd3)
        rk_mem[widx[5:2]] <= {win[5], win[6], rk_lo_word, kw};
    end
  end

  assign rk = rk_mem[cmd.rk_sel];

  // one inverse round: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns
  logic [127:0] sb, ak, mx;
  always_comb begin
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        sb[127-8*(c*4+r) -: 8] = INV_SBOX[st[127-8*(((c+4-r)%4)*4+r) -: 8]];
    ak = sb ^ rk;
    for (int c = 0; c < 4; c++) mx[127-32*c -: 32] = inv_mix_col(ak[127-32*c -: 32]);
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      st <= ct ^ rk;
      ct_hold <= start_message ? {iv_reg[0], iv_reg[1]} : chain;
    end else if (cmd.rnd_step) begin
      st <= cmd.rnd_last ? ak : mx;
    end
    if (cmd.out_load) pt <= st ^ chain_sel;
  end
  assign chain_sel = ct_hold;
endmodule

// ===== tb/tb_aes256_cbc_decrypt_core.sv =====
// Testbench for aes256_cbc_decrypt_core: directed blocks, some with known answers,
// then random CBC messages checked against a built-in AES-256 decrypt predictor.
// Depends on aes_cbc_pkg, aes_cbc_stream_if and the core RTL.
module tb_aes256_cbc_decrypt_core;
  import aes_cbc_pkg::*;

  // Beat layouts as described at the head of the core.
  typedef struct packed {
    logic [63:0] ct_high;
    logic [63:0] ct_low;
    logic        start_message;
  } ct_beat_t;

  typedef struct packed {
    logic [63:0] pt_high;
    logic [63:0] pt_low;
  } pt_beat_t;

  typedef enum logic { ROW_CFG, ROW_BEAT } row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [2:0]   idx;     // register index for config rows
    logic [63:0]  hi;      // config data, or ct_high
    logic [63:0]  lo;      // ct_low
    logic         sm;      // start_message
    bit           known;   // expected plaintext typed in below
    logic [63:0]  exp_hi;
    logic [63:0]  exp_lo;
  } dir_row_t;

  // Indexes past the register list; writes there must be dropped.
  localparam logic [2:0] REG_UNUSED_6 = 3'd6;
  localparam logic [2:0] REG_UNUSED_7 = 3'd7;
  localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
  localparam int IDLE_LIMIT = 4000;   // watchdog, cycles without any beat
  localparam int SETTLE = 80;         // idle time after the core drains
  localparam int NUM_PHASES = 10;
  localparam int PHASE_BEATS = 145;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [RegIdxW-1:0] cfg_idx = '0;
  logic [RegW-1:0] cfg_data = '0;

  aes_cbc_stream_if #(.payload_t(ct_beat_t)) ct_if ();
  aes_cbc_stream_if #(.payload_t(pt_beat_t)) pt_if ();

  aes256_cbc_decrypt_core DUT (
    .clk      (clk),
    .rst      (rst),
    .in_s     (ct_if.sink),
    .out_s    (pt_if.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    ct_if.valid = 1'b0;
    ct_if.payload = '0;
    pt_if.ready = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor: mirrored registers, chaining value and round keys.
  // ---------------------------------------------------------------------
  logic [63:0]  shadow_regs [6];
  logic [63:0]  chain_hi, chain_lo;
  logic [127:0] round_key [15];
  bit           round_keys_valid;

  pt_beat_t plaintext_q [$];   // plaintexts still owed by the core
  int       err_cnt = 0;
  bit       in_beat;

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input int y);
    logic [7:0] acc;
    acc = 8'h00;
    for (int b = 0; b < 4; b++) begin
      if (y[b]) acc ^= x;
      x = gf_dbl(x);
    end
    return acc;
  endfunction

  function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  // Byte i = column*4 + row; row r rotates right by r columns.
  function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127-8*(c*4+r) -: 8] = INV_SBOX[byte_at(s, ((c + 4 - r) % 4) * 4 + r)];
    return o;
  endfunction

  function automatic logic [127:0] unmix_columns(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a, b, d, e;
    for (int c = 0; c < 4; c++) begin
      a = byte_at(s, c*4);
      b = byte_at(s, c*4+1);
      d = byte_at(s, c*4+2);
      e = byte_at(s, c*4+3);
      o[127-8*(c*4)   -: 8] = gf_mul(a,14) ^ gf_mul(b,11) ^ gf_mul(d,13) ^ gf_mul(e,9);
      o[127-8*(c*4+1) -: 8] = gf_mul(a,9) ^ gf_mul(b,14) ^ gf_mul(d,11) ^ gf_mul(e,13);
      o[127-8*(c*4+2) -: 8] = gf_mul(a,13) ^ gf_mul(b,9) ^ gf_mul(d,14) ^ gf_mul(e,11);
      o[127-8*(c*4+3) -: 8] = gf_mul(a,11) ^ gf_mul(b,13) ^ gf_mul(d,9) ^ gf_mul(e,14);
    end
    return o;
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rcon;
    rcon = 8'h01;
    for (int i = 0; i < 8; i++)
      w[i] = (i % 2) ? shadow_regs[i/2][31:0] : shadow_regs[i/2][63:32];
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = gf_dbl(rcon);
      end else if (i % 8 == 4) begin
        t = sbox_word(t);
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r < 15; r++)
      round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    round_keys_valid = 1'b1;
  endfunction

  // CBC plaintext for one accepted ciphertext beat; advances the chain.
  function automatic pt_beat_t cbc_plaintext(input ct_beat_t ct);
    logic [127:0] s;
    logic [127:0] chain;
    if (!round_keys_valid) expand_round_keys();
    chain = ct.start_message ? {shadow_regs[REG_IV_HI], shadow_regs[REG_IV_LO]}
                             : {chain_hi, chain_lo};
    s = {ct.ct_high, ct.ct_low} ^ round_key[14];
    for (int r = 13; r > 0; r--)
      s = unmix_columns(unshift_unsub(s) ^ round_key[r]);
    s = unshift_unsub(s) ^ round_key[0] ^ chain;
    chain_hi = ct.ct_high;
    chain_lo = ct.ct_low;
    return '{pt_high: s[127:64], pt_low: s[63:0]};
  endfunction

  // ---------------------------------------------------------------------
  // Plaintext side: random back-pressure and checking.
  // ---------------------------------------------------------------------
  bit steady_mode = 1'b0;   // no idling on either side
  int hold_request = 0;     // long receiver hold, set by the stimulus
  int stall_left = 0;

  always @(posedge clk) begin
    pt_beat_t exp_pt;
    if (rst) begin
      pt_if.ready <= 1'b0;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        if (plaintext_q.size() == 0) begin
          $error("plaintext beat with nothing expected: %h %h",
                 pt_if.payload.pt_high, pt_if.payload.pt_low);
          err_cnt++;
        end else begin
          exp_pt = plaintext_q.pop_front();
          if (pt_if.payload.pt_high !== exp_pt.pt_high) begin
            $error("pt_high: expected %h, got %h", exp_pt.pt_high, pt_if.payload.pt_high);
            err_cnt++;
          end
          if (pt_if.payload.pt_low !== exp_pt.pt_low) begin
            $error("pt_low: expected %h, got %h", exp_pt.pt_low, pt_if.payload.pt_low);
            err_cnt++;
          end
        end
      end
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        pt_if.ready <= 1'b0;
      end else if (steady_mode || $urandom_range(99) < 70) begin
        pt_if.ready <= 1'b1;
      end else begin
        // mostly short stalls, now and then a long one
        stall_left = ($urandom_range(99) < 90) ? $urandom_range(2) : $urandom_range(60, 20);
        pt_if.ready <= 1'b0;
      end
    end
  end

  // Watchdog: cycles with no beat on either side.
  int idle_cnt = 0;
  always @(posedge clk) begin
    in_beat = ct_if.valid && ct_if.ready;
    if (rst || in_beat || (pt_if.valid && pt_if.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus tasks. All are entered right after a rising edge.
  // ---------------------------------------------------------------------
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    if (idx <= REG_IV_LO) begin
      shadow_regs[idx] = data;
      if (idx <= REG_KEY3) round_keys_valid = 1'b0;
    end
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every plaintext has come back, then let the core settle.
  task automatic drain_core();
    ct_if.valid <= 1'b0;
    while (plaintext_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Offers one ciphertext beat and returns after the edge that takes it.
  // The expected plaintext is either typed in or predicted.
  task automatic send_block(input ct_beat_t ct, input bit known,
                            input logic [63:0] eh, input logic [63:0] el);
    pt_beat_t pred;
    ct_if.valid <= 1'b1;
    ct_if.payload <= ct;
    do @(posedge clk); while (!ct_if.ready);
    pred = cbc_plaintext(ct);
    if (known) pred = '{pt_high: eh, pt_low: el};
    plaintext_q = {plaintext_q, pred};
  endtask

  task automatic sender_gap();
    int n;
    if (steady_mode) return;
    n = $urandom_range(99);
    if (n < 60) return;
    ct_if.valid <= 1'b0;
    if (n < 95) repeat ($urandom_range(3, 1)) @(posedge clk);
    else repeat ($urandom_range(60, 15)) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    int sel;
    sel = $urandom_range(39);
    if (sel == 0) return '0;
    if (sel == 1) return ONES;
    return {$urandom, $urandom};
  endfunction

  // Directed rows: reset behavior, known answers, ignored writes, IV timing.
  dir_row_t dir_rows [] = '{
    // chaining right after reset starts from zero, all-zero key
    '{ROW_BEAT, 3'd0, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BEAT, 3'd0, ONES, ONES, 1'b1, 1'b0, 64'h0, 64'h0},
    '{ROW_BEAT, 3'd0, 64'h0, ONES, 1'b0, 1'b0, 64'h0, 64'h0},
    // single-block known answer, IV still zero
    '{ROW_CFG, REG_KEY0, 64'h0001020304050607, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, REG_KEY1, 64'h08090a0b0c0d0e0f, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, REG_KEY2, 64'h1011121314151617, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, REG_KEY3, 64'h18191a1b1c1d1e1f, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BEAT, 3'd0, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1, 1'b1,
      64'h0011223344556677, 64'h8899aabbccddeeff},
    // two-block CBC known answer
    '{ROW_CFG, REG_KEY0, 64'h603deb1015ca71be, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, REG_KEY1, 64'h2b73aef0857d7781, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, REG_KEY2, 64'h1f352c073b6108d7, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, REG_KEY3, 64'h2d9810a30914dff4, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, REG_IV_HI, 64'h0001020304050607, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, REG_IV_LO, 64'h08090a0b0c0d0e0f, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BEAT, 3'd0, 64'hf58c4c04d6e5f1ba, 64'h779eabfb5f7bfbd6, 1'b1, 1'b1,
      64'h6bc1bee22e409f96, 64'he93d7e117393172a},
    '{ROW_BEAT, 3'd0, 64'h9cfc4e967edb808d, 64'h679f777bc6702c7d, 1'b0, 1'b1,
      64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51},
    // writes past the register list change nothing
    '{ROW_CFG, REG_UNUSED_6, ONES, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, REG_UNUSED_7, ONES, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BEAT, 3'd0, 64'hf58c4c04d6e5f1ba, 64'h779eabfb5f7bfbd6, 1'b1, 1'b1,
      64'h6bc1bee22e409f96, 64'he93d7e117393172a},
    // a new IV leaves the running chain alone
    '{ROW_CFG, REG_IV_HI, ONES, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BEAT, 3'd0, 64'h9cfc4e967edb808d, 64'h679f777bc6702c7d, 1'b0, 1'b1,
      64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51},
    '{ROW_BEAT, 3'd0, ONES, 64'h0, 1'b1, 1'b0, 64'h0, 64'h0},
    // key words 0 and 3 set to all ones
    '{ROW_CFG, REG_KEY0, ONES, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, REG_KEY3, ONES, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BEAT, 3'd0, 64'h0, 64'h0, 1'b1, 1'b0, 64'h0, 64'h0}
  };

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    bit writing;
    ct_beat_t ct;
    for (int i = 0; i < 6; i++) shadow_regs[i] = '0;
    chain_hi = '0;
    chain_lo = '0;
    round_keys_valid = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: config rows only once the core has gone idle.
    writing = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!writing) drain_core();
        writing = 1'b1;
        reg_write(dir_rows[i].idx, dir_rows[i].hi);
      end else begin
        if (writing) end_writes();
        writing = 1'b0;
        send_block('{ct_high: dir_rows[i].hi, ct_low: dir_rows[i].lo,
                     start_message: dir_rows[i].sm},
                   dir_rows[i].known, dir_rows[i].exp_hi, dir_rows[i].exp_lo);
        sender_gap();
      end
    end

    // Random phases: new registers, then CBC messages of random length.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_core();
      steady_mode = (p % 4 == 1);
      for (int r = REG_KEY0; r <= REG_IV_LO; r++) begin
        if (p == 0 || $urandom_range(1)) begin
          case (p)
            2: reg_write(r[2:0], '0);
            5: reg_write(r[2:0], ONES);
            default: reg_write(r[2:0], rand_word());
          endcase
        end
      end
      if ($urandom_range(3) == 0)
        reg_write($urandom_range(1) ? REG_UNUSED_6 : REG_UNUSED_7, rand_word());
      end_writes();

      // receiver holds off long enough for the core to back up its input
      if (p == 3) hold_request = 400;

      for (int k = 0; k < PHASE_BEATS; k++) begin
        ct.ct_high = rand_word();
        ct.ct_low = rand_word();
        ct.start_message = (k == 0) || ($urandom_range(9) == 0);
        send_block(ct, 1'b0, '0, '0);
        // sender pauses until every plaintext is back
        if (p == 6 && k == PHASE_BEATS / 2) begin
          ct_if.valid <= 1'b0;
          while (plaintext_q.size() != 0) @(posedge clk);
        end else begin
          sender_gap();
        end
      end
    end
    steady_mode = 1'b0;

    ct_if.valid <= 1'b0;
    while (plaintext_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/aes_cbc_pkg.sv
rtl/aes_cbc_stream_if.sv
rtl/aes_cbc_ctrl.sv
rtl/aes_cbc_datapath.sv
rtl/aes256_cbc_decrypt_core.sv
tb/tb_aes256_cbc_decrypt_core.sv
